// ===== rtl/core/bcd_long_divider_top_defines.svh =====
// Assertion macros shared by the divider RTL.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef BCD_LONG_DIVIDER_TOP_DEFINES_SVH
`define BCD_LONG_DIVIDER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bld_pkg.sv =====
package bld_pkg;

    // Port width of the packed BCD fields
    localparam int WORD_W         = 64;
    // Bits in one BCD digit
    localparam int NIB_W          = 4;
    // Default number of BCD digits
    localparam int DIGITS_DEFAULT = 16;

    // Decimal digit constants
    localparam logic [NIB_W-1:0] MAX_DIGIT = 4'd9;
    localparam logic [NIB_W-1:0] TEN       = 4'd10;
    localparam logic [NIB_W-1:0] SIX       = 4'd6;

endpackage

// ===== rtl/core/bcd_long_divider_top.sv =====
// Channel | Direction | Handshake         | Fields
// in      | input     | in_valid/in_stall | dividend_bcd, divisor_bcd
// out     | output    | out_valid/out_stall | quotient_bcd, remainder_bcd,
//         |           |                   | divide_by_zero, bad_digit
//
// Sequence: after acceptance the divider shifts in the leading dividend digit, then
// runs trial subtractions; a failing trial closes the quotient digit and shifts in the
// next dividend digit. After the last digit the result goes to the output register
// and the input takes the next transaction. One decimal trial subtraction per cycle.
// A flagged transaction (zero divisor or non-BCD nibble) skips straight to hand-over.
// Reset clears the sequencer and the output valid; data registers are not reset.
// The output register holds a finished result under out_stall while the next
// transaction is accepted and divided; the sequencer waits only to hand over.
`include "bcd_long_divider_top_defines.svh"

module bcd_long_divider_top #(
    parameter int DIGITS = bld_pkg::DIGITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [bld_pkg::WORD_W-1:0] dividend_bcd,
    input  logic [bld_pkg::WORD_W-1:0] divisor_bcd,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bld_pkg::WORD_W-1:0] quotient_bcd,
    output logic [bld_pkg::WORD_W-1:0] remainder_bcd,
    output logic                      divide_by_zero,
    output logic                      bad_digit
);

    localparam int NW    = bld_pkg::NIB_W;
    localparam int OPD_W = NW * DIGITS;          // operand width
    localparam int D1    = DIGITS + 1;           // partial remainder digits
    localparam int REM_W = NW * D1;
    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam logic [REM_W-1:0] SIX_PAT = {D1{bld_pkg::SIX}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_TRIAL,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [OPD_W-1:0]   dvd_reg, dvd_next;
    logic [OPD_W-1:0]   dvs_reg, dvs_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [OPD_W-1:0]   quo_reg, quo_next;
    logic [NW-1:0]      qdig_reg, qdig_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               zero_reg, zero_next;
    logic               bad_reg, bad_next;
    logic               out_valid_reg, out_valid_next;
    logic [OPD_W-1:0]   out_quo_reg, out_quo_next;
    logic [OPD_W-1:0]   out_rem_reg, out_rem_next;
    logic               out_zero_reg, out_zero_next;
    logic               out_bad_reg, out_bad_next;

    logic               in_bad;
    logic               in_zero;
    logic [REM_W-1:0]   b_ext;
    logic [REM_W-1:0]   b_nines;
    logic [REM_W-1:0]   t_bias;
    logic [REM_W:0]     t_sum;
    logic [REM_W-1:0]   diff;
    logic               fits;
    logic               out_free;

    // Check the used nibbles of both operands at the input
    always_comb
    begin
        in_bad = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if ((dividend_bcd[NW*i +: NW] > bld_pkg::MAX_DIGIT) ||
                (divisor_bcd[NW*i +: NW] > bld_pkg::MAX_DIGIT))
            begin
                in_bad = 1'b1;
            end
        end
        in_zero = (divisor_bcd[OPD_W-1:0] == '0);
    end

    // Decimal subtract: partial remainder minus divisor by nines' complement add
    always_comb
    begin
        b_ext = {{NW{1'b0}}, dvs_reg};
        for (int i = 0; i < D1; i++)
        begin
            b_nines[NW*i +: NW] = bld_pkg::MAX_DIGIT - b_ext[NW*i +: NW];
        end
        t_bias = rem_reg + SIX_PAT;
        t_sum  = {1'b0, t_bias} + {1'b0, b_nines} + {{REM_W{1'b0}}, 1'b1};
        // Drop the bias of every digit that gave no decimal carry
        for (int i = 0; i < D1; i++)
        begin
            if (i == D1 - 1)
            begin
                diff[NW*i +: NW] = t_sum[REM_W] ? t_sum[NW*i +: NW]
                                                : t_sum[NW*i +: NW] + bld_pkg::TEN;
            end
            else if (t_bias[NW*(i+1)] ^ b_nines[NW*(i+1)] ^ t_sum[NW*(i+1)])
            begin
                diff[NW*i +: NW] = t_sum[NW*i +: NW];
            end
            else
            begin
                diff[NW*i +: NW] = t_sum[NW*i +: NW] + bld_pkg::TEN;
            end
        end
        fits = t_sum[REM_W];
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequence one transaction digit by digit
    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qdig_next      = qdig_reg;
        cnt_next       = cnt_reg;
        zero_next      = zero_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_quo_next   = out_quo_reg;
        out_rem_next   = out_rem_reg;
        out_zero_next  = out_zero_reg;
        out_bad_next   = out_bad_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dvd_next   = dividend_bcd[OPD_W-1:0];
                    dvs_next   = divisor_bcd[OPD_W-1:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    qdig_next  = '0;
                    cnt_next   = CNT_W'(DIGITS);
                    zero_next  = in_zero;
                    bad_next   = in_bad;
                    state_next = (in_zero || in_bad) ? S_FINISH : S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // Bring in the leading dividend digit
                rem_next   = {rem_reg[REM_W-NW-1:0], dvd_reg[OPD_W-1 -: NW]};
                dvd_next   = dvd_reg << NW;
                qdig_next  = '0;
                state_next = S_TRIAL;
            end
            S_TRIAL:
            begin
                if (fits)
                begin
                    // Keep the difference and count one more multiple
                    rem_next  = diff;
                    qdig_next = qdig_reg + 4'd1;
                end
                else
                begin
                    // Close this quotient digit and advance to the next one
                    quo_next = OPD_W'({quo_reg, qdig_reg});
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        rem_next  = {rem_reg[REM_W-NW-1:0], dvd_reg[OPD_W-1 -: NW]};
                        dvd_next  = dvd_reg << NW;
                        qdig_next = '0;
                    end
                end
            end
            S_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_quo_next   = quo_reg;
                    out_rem_next   = rem_reg[OPD_W-1:0];
                    out_zero_next  = zero_reg;
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        qdig_reg     <= qdig_next;
        cnt_reg      <= cnt_next;
        zero_reg     <= zero_next;
        bad_reg      <= bad_next;
        out_quo_reg  <= out_quo_next;
        out_rem_reg  <= out_rem_next;
        out_zero_reg <= out_zero_next;
        out_bad_reg  <= out_bad_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign quotient_bcd   = bld_pkg::WORD_W'(out_quo_reg);
    assign remainder_bcd  = bld_pkg::WORD_W'(out_rem_reg);
    assign divide_by_zero = out_zero_reg;
    assign bad_digit      = out_bad_reg;

    // A new result only ever comes from the hand-over step
    `BLD_ASSERT_SAME(a_out_from_finish, $rose(out_valid_reg),
                     $past(state_reg == S_FINISH), "result appeared outside hand-over")
    // Flagged results carry a zero payload
    `BLD_ASSERT_SAME(a_flag_zero, out_valid_reg && (out_zero_reg || out_bad_reg),
                     (out_quo_reg == '0) && (out_rem_reg == '0),
                     "flagged result with nonzero payload")
    // Trial count never passes nine
    `BLD_ASSERT_SAME(a_qdig_range, state_reg == S_TRIAL,
                     qdig_reg <= bld_pkg::MAX_DIGIT, "quotient digit above nine")
    // A stalled result stays valid
    `BLD_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg,
                     "stalled result dropped")

endmodule
